@@ src/shem_pkg.sv @@
package shem_pkg;

    localparam int MAX_CLUSTER_WIDTH = 64;

    localparam int CW_IN_W  = 7;
    localparam int W_W      = $clog2(MAX_CLUSTER_WIDTH + 1);
    localparam int SLOPE_W  = 24;
    localparam int CFG_W    = 16;
    localparam int ES_W     = 16;
    localparam int VAR_W    = 40;
    localparam int PROD_W   = SLOPE_W + CFG_W;
    localparam int RATIO_SH = 12;
    localparam int Q_W      = PROD_W - RATIO_SH;
    localparam int A_W      = W_W + CFG_W;
    localparam int B_W      = A_W;
    localparam int S_W      = Q_W + 2;
    localparam int C_W      = B_W + S_W - 16;
    localparam int E_W      = C_W + ES_W - 12;
    localparam int E_SAT_W  = VAR_W / 2;

    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 80;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_ASPECT     = 1'b0;
    localparam logic REG_RESOLUTION = 1'b1;

    localparam logic [CFG_W-1:0] ASPECT_RESET     = 16'd4096;
    localparam logic [CFG_W-1:0] RESOLUTION_RESET = 16'd3146;

    localparam logic [Q_W-1:0] R_1P2 = Q_W'(78643);
    localparam logic [Q_W-1:0] R_0P7 = Q_W'(45875);
    localparam logic [Q_W-1:0] R_0P9 = Q_W'(58982);
    localparam logic [15:0]    K_INV1P2  = 16'd54613;
    localparam logic [S_W-1:0] K_QUARTER = S_W'(16384);
    localparam logic [15:0]    K_0P6     = 16'd39322;

    typedef struct packed {
        logic               is_y;
        logic [ES_W-1:0]    es;
        logic [VAR_W-1:0]   other;
        logic [W_W-1:0]     w;
        logic [B_W-1:0]     b;
    } side_t;

    typedef struct packed {
        logic [Q_W-1:0]     num;
        logic [W_W-1:0]     rem;
        side_t              side;
    } div_t;

endpackage

@@ src/shem_cfg.sv @@
module shem_cfg
    import shem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CFG_W-1:0]   strip_aspect,
    output logic [CFG_W-1:0]   strip_resolution
);

    logic [CFG_W-1:0] aspect_reg;
    logic [CFG_W-1:0] resolution_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aspect_reg     <= ASPECT_RESET;
            resolution_reg <= RESOLUTION_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_ASPECT:     aspect_reg     <= pwdata[CFG_W-1:0];
                REG_RESOLUTION: resolution_reg <= pwdata[CFG_W-1:0];
                default:        aspect_reg     <= aspect_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ASPECT:     prdata = PDATA_W'(aspect_reg);
            REG_RESOLUTION: prdata = PDATA_W'(resolution_reg);
            default:        prdata = '0;
        endcase
    end

    assign strip_aspect     = aspect_reg;
    assign strip_resolution = resolution_reg;

endmodule

@@ src/shem_div_stage.sv @@
module shem_div_stage
    import shem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        div_t          t;
        logic [W_W:0]  r8;
        t  = in_data;
        r8 = '0;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            r8    = {t.rem, t.num[Q_W-1]};
            t.num = {t.num[Q_W-2:0], 1'b0};
            if (r8 >= {1'b0, t.side.w})
            begin
                r8       = r8 - {1'b0, t.side.w};
                t.num[0] = 1'b1;
            end
            t.rem = r8[W_W-1:0];
        end
        data_next = t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < data_reg.side.w))
        else $error("partial remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.side.w != '0))
        else $error("zero divisor in divider pipeline");

endmodule

@@ src/shem_back.sv @@
module shem_back
    import shem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  div_t             in_data,
    output logic             out_valid,
    output logic             measured_axis,
    output logic [VAR_W-1:0] measured_variance,
    output logic [VAR_W-1:0] other_variance_out
);

    logic [Q_W-1:0]  r;
    logic [16:0]     d1;
    logic [32:0]     p1;
    logic [16:0]     t1;
    logic [13:0]     d2;
    logic [16:0]     p2;
    logic [S_W-1:0]  t2;
    logic [S_W-1:0]  t3;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [S_W-1:0]  s_reg;
    logic [S_W-1:0]  s_next;
    logic [B_W-1:0]  b1_reg;
    logic [C_W-1:0]  c_reg;
    logic [B_W+S_W-1:0] pc;
    logic [C_W+ES_W-1:0] pe;
    logic [E_W-1:0]  e;
    logic            sat_reg;
    logic [E_SAT_W-1:0] e_reg;
    logic [VAR_W-1:0] var_reg;
    logic [VAR_W-1:0] var_next;

    logic             y1_reg, y2_reg, y3_reg, y4_reg;
    logic [ES_W-1:0]  es1_reg, es2_reg;
    logic [VAR_W-1:0] o1_reg, o2_reg, o3_reg, o4_reg;

    assign r  = in_data.num;
    assign d1 = 17'(R_1P2 - r);
    assign p1 = K_INV1P2 * d1;
    assign t1 = (r < R_1P2) ? p1[32:16] : '0;
    assign d2 = 14'(r - R_0P7);
    assign p2 = 17'(d2) * 17'd5;

    always_comb
    begin
        if (r > R_0P7 && r <= R_0P9)
            t2 = S_W'(p2[16:2]);
        else if (r > R_0P9)
            t2 = K_QUARTER;
        else
            t2 = '0;
        t3     = (r > R_1P2) ? {r - R_1P2, 2'b00} : '0;
        s_next = S_W'(t1) + t2 + t3;
    end

    assign pc = B_W'(b1_reg) * S_W'(s_reg);
    assign pe = C_W'(c_reg) * ES_W'(es2_reg);
    assign e  = pe[C_W+ES_W-1:12];
    assign var_next = sat_reg ? '1 : VAR_W'(e_reg) * VAR_W'(e_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_next;
            b1_reg  <= in_data.side.b;
            y1_reg  <= in_data.side.is_y;
            es1_reg <= in_data.side.es;
            o1_reg  <= in_data.side.other;

            c_reg   <= pc[B_W+S_W-1:16];
            y2_reg  <= y1_reg;
            es2_reg <= es1_reg;
            o2_reg  <= o1_reg;

            sat_reg <= |e[E_W-1:E_SAT_W];
            e_reg   <= e[E_SAT_W-1:0];
            y3_reg  <= y2_reg;
            o3_reg  <= o2_reg;

            var_reg <= var_next;
            y4_reg  <= y3_reg;
            o4_reg  <= o3_reg;
        end
    end

    assign out_valid          = v4_reg;
    assign measured_axis      = y4_reg;
    assign measured_variance  = var_reg;
    assign other_variance_out = o4_reg;

    a_saturate_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v3_reg && sat_reg) |=> (var_reg == '1))
        else $error("saturated error did not give full-scale variance");

endmodule

@@ src/strip_hit_error_model.sv @@
// Strip hit error model: one silicon-strip hit in, one variance pair out.
// Input stream s_*: one transaction per hit. s_tuser carries view_is_y.
// s_tdata from bit 0: cluster_width[6:0], x_slope[30:7], y_slope[54:31],
// error_scale[70:55], other_variance_in[110:71], bit 111 zero.
// Output stream m_*: one transaction per hit, in order. m_tuser carries
// measured_axis; m_tdata: measured_variance[39:0], other_variance_out[79:40].
// Configuration over APB: strip_aspect at 0x0, strip_resolution at 0x4,
// written by the user only while no hit is in flight (the block does not
// enforce this); pready is always high. Two front stages (slope magnitude
// times aspect and width times resolution, then the 0.6 scale), seven
// divider stages of four quotient bits each for the ratio, four back stages
// (scale, two multiplies, square). Throughput is one hit per cycle unless
// stalled: when the receiver holds m_tready low with a result waiting, the
// whole pipeline holds and s_tready falls; nothing is lost or repeated.
// Reset clears all valid bits and restores the register defaults.
module strip_hit_error_model
    import shem_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // cluster_width, x_slope, y_slope, error_scale, other_variance_in
    input  logic                   s_tuser,  // view_is_y
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // measured_variance, other_variance_out
    output logic                   m_tuser,  // measured_axis
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic [CFG_W-1:0]   strip_aspect;
    logic [CFG_W-1:0]   strip_resolution;
    logic               adv;

    logic [CW_IN_W-1:0] cw;
    logic signed [SLOPE_W-1:0] x_slope;
    logic signed [SLOPE_W-1:0] y_slope;
    logic signed [SLOPE_W-1:0] slope;
    logic [SLOPE_W-1:0] mag;
    logic [W_W-1:0]     w_next;

    logic               v1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [A_W-1:0]     a_reg;
    logic [W_W-1:0]     w_reg;
    logic               y_reg;
    logic [ES_W-1:0]    es_reg;
    logic [VAR_W-1:0]   o_reg;

    logic [A_W+15:0]    pb;
    logic               v2_reg;
    div_t               d0_reg;
    div_t               d0_next;

    logic               dv [0:DIV_STAGES];
    div_t               dd [0:DIV_STAGES];

    logic               out_valid;
    logic               axis;
    logic [VAR_W-1:0]   mvar;
    logic [VAR_W-1:0]   ovar;

    shem_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .strip_aspect     (strip_aspect),
        .strip_resolution (strip_resolution)
    );

    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    assign cw      = s_tdata[6:0];
    assign x_slope = s_tdata[30:7];
    assign y_slope = s_tdata[54:31];
    assign slope   = s_tuser ? y_slope : x_slope;
    assign mag     = slope[SLOPE_W-1] ? SLOPE_W'(~slope + 1'b1) : SLOPE_W'(slope);

    always_comb
    begin
        if (cw == '0)
            w_next = W_W'(1);
        else if (int'(cw) > MAX_CLUSTER_WIDTH)
            w_next = W_W'(MAX_CLUSTER_WIDTH);
        else
            w_next = W_W'(cw);
    end

    assign pb = a_reg * K_0P6;

    always_comb
    begin
        d0_next.num        = prod_reg[PROD_W-1:RATIO_SH];
        d0_next.rem        = '0;
        d0_next.side.is_y  = y_reg;
        d0_next.side.es    = es_reg;
        d0_next.side.other = o_reg;
        d0_next.side.w     = w_reg;
        d0_next.side.b     = pb[A_W+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= mag * strip_aspect;
            a_reg    <= w_next * strip_resolution;
            w_reg    <= w_next;
            y_reg    <= s_tuser;
            es_reg   <= s_tdata[70:55];
            o_reg    <= s_tdata[110:71];
            d0_reg   <= d0_next;
        end
    end

    assign dv[0] = v2_reg;
    assign dd[0] = d0_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        shem_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (dv[g]),
            .in_data   (dd[g]),
            .out_valid (dv[g+1]),
            .out_data  (dd[g+1])
        );
    end

    shem_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (adv),
        .in_valid           (dv[DIV_STAGES]),
        .in_data            (dd[DIV_STAGES]),
        .out_valid          (out_valid),
        .measured_axis      (axis),
        .measured_variance  (mvar),
        .other_variance_out (ovar)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = axis;
    assign m_tdata  = {ovar, mvar};

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_stall_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (v1_reg == $past(v1_reg)))
        else $error("front stage moved during stall");

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shem_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [PADDR_W-1:0] ADDR_ASPECT     = {REG_ASPECT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_RESOLUTION = {REG_RESOLUTION, 2'b00};

    localparam bit [63:0] RATIO_1P2     = 64'd78643;
    localparam bit [63:0] RATIO_0P7     = 64'd45875;
    localparam bit [63:0] RATIO_0P9     = 64'd58982;
    localparam bit [63:0] INV_1P2_Q16   = 64'd54613;
    localparam bit [63:0] QUARTER_Q16   = 64'd16384;
    localparam bit [63:0] SIXTENTHS_Q16 = 64'd39322;
    localparam bit [63:0] E_SATURATE    = 64'd1 << 20;

    typedef struct {
        logic [6:0]  width;
        logic        is_y;
        logic [23:0] x_slope;
        logic [23:0] y_slope;
        logic [15:0] err_scale;
        logic [39:0] other_var;
    } hit_t;

    typedef struct {
        logic        axis;
        logic [39:0] meas_var;
        logic [39:0] other_var;
    } var_pair_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    logic [15:0] aspect_q     = 16'd4096;
    logic [15:0] resolution_q = 16'd3146;

    var_pair_t var_pairs_due[$];
    int        mismatches = 0;
    int        cycles     = 0;
    int        stall_left = 0;
    bit        quiet      = 1'b0;

    strip_hit_error_model dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit [63:0] clamp_width(logic [6:0] width);
        bit [63:0] w;
        w = width;
        if (w == 0)
            w = 1;
        if (w > MAX_CLUSTER_WIDTH)
            w = MAX_CLUSTER_WIDTH;
        return w;
    endfunction

    function automatic var_pair_t hit_variance(hit_t h);
        bit [63:0] w;
        bit [23:0] raw;
        bit [63:0] mag;
        bit [63:0] ratio;
        bit [63:0] s;
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] c;
        bit [63:0] e;
        var_pair_t p;
        w     = clamp_width(h.width);
        raw   = h.is_y ? h.y_slope : h.x_slope;
        mag   = raw[23] ? (64'h100_0000 - 64'(raw)) : 64'(raw);
        ratio = (mag * aspect_q) / (w << 12);
        s     = 0;
        if (ratio < RATIO_1P2)
            s += (INV_1P2_Q16 * (RATIO_1P2 - ratio)) >> 16;
        if (ratio > RATIO_0P7 && ratio <= RATIO_0P9)
            s += (64'd5 * (ratio - RATIO_0P7)) >> 2;
        else if (ratio > RATIO_0P9)
            s += QUARTER_Q16;
        if (ratio > RATIO_1P2)
            s += 64'd4 * (ratio - RATIO_1P2);
        a = w * resolution_q;
        b = (a * SIXTENTHS_Q16) >> 16;
        c = (b * s) >> 16;
        e = (c * h.err_scale) >> 12;
        p.axis      = h.is_y;
        p.meas_var  = (e >= E_SATURATE) ? '1 : 40'(e * e);
        p.other_var = h.other_var;
        return p;
    endfunction

    function automatic hit_t make_hit(logic [6:0] width, logic is_y, logic [23:0] xs,
                                      logic [23:0] ys, logic [15:0] es, logic [39:0] ov);
        hit_t h;
        h.width     = width;
        h.is_y      = is_y;
        h.x_slope   = xs;
        h.y_slope   = ys;
        h.err_scale = es;
        h.other_var = ov;
        return h;
    endfunction

    function automatic hit_t random_hit();
        hit_t      h;
        int        n;
        bit [63:0] w;
        bit [63:0] target;
        bit [63:0] mag;
        logic [23:0] slope;
        n = $urandom_range(0, 19);
        if (n == 0)
            h.width = 7'd0;
        else if (n == 1)
            h.width = 7'($urandom_range(65, 127));
        else if (n < 4)
            h.width = 7'd64;
        else if (n < 10)
            h.width = 7'($urandom_range(1, 4));
        else
            h.width = 7'($urandom_range(1, 64));
        h.is_y    = 1'($urandom_range(0, 1));
        h.x_slope = 24'($urandom);
        h.y_slope = 24'($urandom);
        if ($urandom_range(0, 9) < 6 && aspect_q != 0)
        begin
            w      = clamp_width(h.width);
            target = $urandom_range(0, 120000);
            mag    = (target * (w << 12)) / aspect_q;
            if (mag > 64'h7F_FFFF)
                mag = 64'h7F_FFFF;
            slope = $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
            if (h.is_y)
                h.y_slope = slope;
            else
                h.x_slope = slope;
        end
        n = $urandom_range(0, 19);
        if (n == 0)
            h.err_scale = 16'd0;
        else if (n == 1)
            h.err_scale = 16'hFFFF;
        else if (n < 10)
            h.err_scale = 16'($urandom_range(2048, 8192));
        else
            h.err_scale = 16'($urandom);
        h.other_var = 40'({$urandom, $urandom});
        return h;
    endfunction

    function automatic int pick_idle_len();
        int n;
        if (quiet)
            return 0;
        n = $urandom_range(0, 99);
        if (n < 60)
            return 0;
        if (n < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_register_value();
        int n;
        n = $urandom_range(0, 9);
        if (n == 0)
            return 16'd0;
        if (n == 1)
            return 16'hFFFF;
        if (n < 6)
            return 16'($urandom_range(1024, 16384));
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("cycle %0d: %s mismatch, got %0h expected %0h", cycles, what, got, want);
    endtask

    task automatic send_hit(hit_t h);
        int gap;
        gap = pick_idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= h.is_y;
        s_tdata  <= {1'b0, h.other_var, h.err_scale, h.y_slope, h.x_slope, h.width};
        do
            @(posedge clk);
        while (!s_tready);
        var_pairs_due.push_back(hit_variance(h));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (var_pairs_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [15:0] value);
        logic [PDATA_W-1:0] word;
        word = {16'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ASPECT)
            aspect_q = value;
        else if (addr == ADDR_RESOLUTION)
            resolution_q = value;
        @(posedge clk);
    endtask

    task automatic set_registers(logic [15:0] aspect, logic [15:0] resolution);
        wait_drained();
        apb_write(ADDR_ASPECT, aspect);
        apb_write(ADDR_RESOLUTION, resolution);
    endtask

    task automatic test_field_extremes();
        send_hit(make_hit(7'd0, 1'b0, 24'h00_0000, 24'h00_0000, 16'd4096, 40'd0));
        send_hit(make_hit(7'd65, 1'b1, 24'h00_0000, 24'h00_0000, 16'd4096, '1));
        send_hit(make_hit(7'd127, 1'b0, 24'h7F_FFFF, 24'h80_0000, 16'hFFFF, 40'h55_5555_5555));
        send_hit(make_hit(7'd64, 1'b1, 24'h80_0000, 24'h7F_FFFF, 16'd4096, 40'hAA_AAAA_AAAA));
        send_hit(make_hit(7'd1, 1'b0, 24'h80_0000, 24'h7F_FFFF, 16'd4096, 40'd1));
        send_hit(make_hit(7'd1, 1'b1, 24'h7F_FFFF, 24'h80_0000, 16'd4096, 40'd2));
        send_hit(make_hit(7'd1, 1'b0, 24'h7F_FFFF, 24'h00_0000, 16'hFFFF, 40'd3));
        send_hit(make_hit(7'd1, 1'b1, 24'h00_0000, 24'h7F_FFFF, 16'd0, 40'd4));
        send_hit(make_hit(7'd1, 1'b0, 24'h00_0000, 24'h00_0000, 16'hFFFF, '1));
        send_hit(make_hit(7'd1, 1'b0, 24'hFF_FFFF, 24'h00_0001, 16'd4096, 40'd5));
    endtask

    task automatic test_scale_breakpoints();
        int unsigned points[10] = '{0, 45874, 45875, 45876, 58981, 58982, 58983,
                                    78642, 78643, 78644};
        logic [23:0] slope;
        foreach (points[i])
        begin
            slope = (i % 2) ? 24'(-points[i]) : 24'(points[i]);
            send_hit(make_hit(7'd1, 1'(i % 2), slope, slope, 16'd4096, 40'(i)));
        end
    endtask

    task automatic test_register_extremes();
        set_registers(16'd0, 16'd0);
        send_hit(make_hit(7'd64, 1'b0, 24'h7F_FFFF, 24'h00_0000, 16'hFFFF, 40'd6));
        send_hit(make_hit(7'd1, 1'b1, 24'h00_0000, 24'h80_0000, 16'hFFFF, 40'd7));
        set_registers(16'hFFFF, 16'hFFFF);
        send_hit(make_hit(7'd64, 1'b0, 24'h00_0000, 24'h00_0000, 16'd4096, 40'd8));
        send_hit(make_hit(7'd1, 1'b1, 24'h00_0000, 24'h80_0000, 16'hFFFF, 40'd9));
        send_hit(make_hit(7'd64, 1'b0, 24'h00_4000, 24'h00_0000, 16'd256, 40'd10));
    endtask

    task automatic test_random_streams();
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_registers(16'd4096, 16'd3146);
            else
                set_registers(pick_register_value(), pick_register_value());
            quiet = (phase == 2);
            repeat (250)
                send_hit(random_hit());
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left <= pick_idle_len();
        end
    end

    always @(posedge clk)
    begin
        var_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (var_pairs_due.size() == 0)
            begin
                report_mismatch("unexpected transaction", m_tdata[39:0], 40'd0);
            end
            else
            begin
                want = var_pairs_due.pop_front();
                if (m_tuser !== want.axis)
                    report_mismatch("measured_axis", 40'(m_tuser), 40'(want.axis));
                if (m_tdata[39:0] !== want.meas_var)
                    report_mismatch("measured_variance", m_tdata[39:0], want.meas_var);
                if (m_tdata[79:40] !== want.other_var)
                    report_mismatch("other_variance_out", m_tdata[79:40], want.other_var);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_scale_breakpoints();
        test_register_extremes();
        test_random_streams();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
